@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL (included by prrq_seq).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/prrq_pkg.sv @@
`default_nettype none
package prrq_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int NUM_LEVELS  = 4;

  // field widths of the channel beats
  localparam int ID_W    = 6;
  localparam int LEVEL_W = 2;

  // internal index widths
  localparam int ENT_W = $clog2(NUM_ENTRIES);
  localparam int LVL_W = $clog2(NUM_LEVELS);

  localparam logic CMD_FIRE = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  typedef struct packed {
    logic               served_valid;
    logic [ID_W-1:0]    served_id;
    logic [LEVEL_W-1:0] served_level;
    logic               fire_ignored;
    logic [LEVEL_W-1:0] level_now;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [ENT_W-1:0] addr;
    logic [ENT_W-1:0] data;
  } link_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/priority_round_robin_ready_queue_top.sv @@
`default_nettype none
// Multilevel priority FIFO ready queue.
// Input channel (in_valid/in_ready): one beat is a command. in_cmd = fire
// appends in_entry_id to the FIFO of in_level; in_cmd = take serves the
// oldest entry of the highest non-empty level at or below the active level.
// Output channel (out_valid/out_ready): exactly one result beat per command,
// in command order (served id/level, fire dropped flag, active level).
// Fire goes from decode to done when dropped or its level is empty, else
// through link and tail states to append to a non-empty ring. Take scans
// down past empty levels (at most NUM_LEVELS-1) to done if none is left,
// else to a head state and, unless the ring holds one entry, a next state.
// One command at a time; in_ready rises at the same edge as out_valid. The
// steps follow from the link RAM (one registered read and one write per
// cycle) and the one-level-per-cycle step down of the active level.
// A finished result waits in the output register while the next command is
// taken; if that one finishes while out_ready is still low, the sequencer
// holds in its done state and in_ready stays low.
// Reset (rst_n low, synchronous) empties all levels and sets level 0; the
// link RAM is not cleared; its read data is only used for entries that are queued.
module priority_round_robin_ready_queue_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_cmd,
  input  wire logic [prrq_pkg::ID_W-1:0]    in_entry_id,
  input  wire logic [prrq_pkg::LEVEL_W-1:0] in_level,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_served_valid,
  output logic      [prrq_pkg::ID_W-1:0]    out_served_id,
  output logic      [prrq_pkg::LEVEL_W-1:0] out_served_level,
  output logic                              out_fire_ignored,
  output logic      [prrq_pkg::LEVEL_W-1:0] out_level_now
);

  logic                         seq_idle;
  logic                         seq_done;
  prrq_pkg::res_t               seq_res;
  logic [prrq_pkg::ENT_W-1:0]   ram_raddr;
  logic [prrq_pkg::ENT_W-1:0]   ram_rdata;
  prrq_pkg::link_wr_t           ram_wr;

  logic           out_valid_r, out_valid_nxt;
  prrq_pkg::res_t out_res_r, out_res_nxt;
  logic           slot_free;
  logic           load;

  // output slot frees when empty or drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign load      = seq_done && slot_free;
  assign in_ready  = seq_idle;

  prrq_link_ram #(
    .DEPTH (prrq_pkg::NUM_ENTRIES),
    .WIDTH (prrq_pkg::ENT_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prrq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .cmd_in    (in_cmd),
    .id_in     (in_entry_id),
    .level_in  (in_level),
    .slot_free (slot_free),
    .idle      (seq_idle),
    .done      (seq_done),
    .res       (seq_res),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_wr    (ram_wr)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = seq_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_served_valid = out_res_r.served_valid;
  assign out_served_id    = out_res_r.served_id;
  assign out_served_level = out_res_r.served_level;
  assign out_fire_ignored = out_res_r.fire_ignored;
  assign out_level_now    = out_res_r.level_now;

endmodule
`default_nettype wire

@@ hw/rtl/prrq_link_ram.sv @@
`default_nettype none
module prrq_link_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/prrq_seq.sv @@
`default_nettype none
`include "assert_macros.svh"
module prrq_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         cmd_in,
  input  wire logic [prrq_pkg::ID_W-1:0]    id_in,
  input  wire logic [prrq_pkg::LEVEL_W-1:0] level_in,
  input  wire logic                         slot_free,
  output logic                              idle,
  output logic                              done,
  output prrq_pkg::res_t                    res,
  output logic      [prrq_pkg::ENT_W-1:0]   ram_raddr,
  input  wire logic [prrq_pkg::ENT_W-1:0]   ram_rdata,
  output prrq_pkg::link_wr_t                ram_wr
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_F_LINK = 3'd2;
  localparam logic [2:0] S_F_TAIL = 3'd3;
  localparam logic [2:0] S_T_SCAN = 3'd4;
  localparam logic [2:0] S_T_HEAD = 3'd5;
  localparam logic [2:0] S_T_NEXT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [prrq_pkg::LVL_W-1:0] active_r, active_nxt;
  logic [prrq_pkg::NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [prrq_pkg::NUM_ENTRIES-1:0] queued_r, queued_nxt;
  logic [prrq_pkg::ENT_W-1:0] tail_r [prrq_pkg::NUM_LEVELS];
  logic [prrq_pkg::ENT_W-1:0] tail_nxt [prrq_pkg::NUM_LEVELS];
  logic cmd_r, cmd_nxt;
  logic [prrq_pkg::ID_W-1:0] id_r, id_nxt;
  logic [prrq_pkg::LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [prrq_pkg::ENT_W-1:0] t_r, t_nxt;
  logic [prrq_pkg::ENT_W-1:0] h_r, h_nxt;
  prrq_pkg::res_t res_r, res_nxt;

  logic [prrq_pkg::ENT_W-1:0] e_idx;
  logic [prrq_pkg::LVL_W-1:0] lvl_p;
  logic [prrq_pkg::LVL_W-1:0] tail_idx;
  logic [prrq_pkg::ENT_W-1:0] tail_q;
  logic                       ne_q;
  logic                       fire_ign;

  assign e_idx    = prrq_pkg::ENT_W'(id_r);
  assign lvl_p    = prrq_pkg::LVL_W'(lvl_r);
  // one tail/nonempty read port: fire looks at its level, take at the active one
  assign tail_idx = (cmd_r == prrq_pkg::CMD_TAKE) ? active_r : lvl_p;
  assign tail_q   = tail_r[tail_idx];
  assign ne_q     = nonempty_r[tail_idx];
  assign fire_ign = (lvl_r == '0) || (32'(lvl_r) >= prrq_pkg::NUM_LEVELS) ||
                    (32'(id_r) >= prrq_pkg::NUM_ENTRIES) || queued_r[e_idx];

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    nonempty_nxt = nonempty_r;
    queued_nxt   = queued_r;
    tail_nxt     = tail_r;
    cmd_nxt      = cmd_r;
    id_nxt       = id_r;
    lvl_nxt      = lvl_r;
    t_nxt        = t_r;
    h_nxt        = h_r;
    res_nxt      = res_r;
    ram_raddr    = tail_q;
    ram_wr       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_in;
          id_nxt    = id_in;
          lvl_nxt   = level_in;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt = '0;
        if (cmd_r == prrq_pkg::CMD_FIRE) begin
          res_nxt.fire_ignored = fire_ign;
          if (fire_ign) begin
            state_nxt = S_DONE;
          end else if (ne_q) begin
            // append behind the current tail: fetch its link first
            t_nxt     = tail_q;
            state_nxt = S_F_LINK;
          end else begin
            ram_wr              = '{we: 1'b1, addr: e_idx, data: e_idx};
            tail_nxt[lvl_p]     = e_idx;
            nonempty_nxt[lvl_p] = 1'b1;
            queued_nxt[e_idx]   = 1'b1;
            if (lvl_p > active_r) begin
              active_nxt = lvl_p;
            end
            state_nxt = S_DONE;
          end
        end else begin
          if (32'(active_r) >= prrq_pkg::NUM_LEVELS) begin
            active_nxt = prrq_pkg::LVL_W'(prrq_pkg::NUM_LEVELS - 1);
          end
          state_nxt = S_T_SCAN;
        end
      end
      S_F_LINK: begin
        ram_wr    = '{we: 1'b1, addr: e_idx, data: ram_rdata};
        state_nxt = S_F_TAIL;
      end
      S_F_TAIL: begin
        ram_wr            = '{we: 1'b1, addr: t_r, data: e_idx};
        tail_nxt[lvl_p]   = e_idx;
        queued_nxt[e_idx] = 1'b1;
        if (lvl_p > active_r) begin
          active_nxt = lvl_p;
        end
        state_nxt = S_DONE;
      end
      S_T_SCAN: begin
        // one level per cycle through the active-level decrement
        if (active_r != '0 && !ne_q) begin
          active_nxt = active_r - 1'b1;
        end else if (active_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          t_nxt     = tail_q;
          state_nxt = S_T_HEAD;
        end
      end
      S_T_HEAD: begin
        h_nxt     = ram_rdata;
        ram_raddr = ram_rdata;
        if (ram_rdata == t_r) begin
          nonempty_nxt[active_r] = 1'b0;
          queued_nxt[ram_rdata]  = 1'b0;
          res_nxt.served_valid   = 1'b1;
          res_nxt.served_id      = prrq_pkg::ID_W'(ram_rdata);
          res_nxt.served_level   = prrq_pkg::LEVEL_W'(active_r);
          state_nxt              = S_DONE;
        end else begin
          state_nxt = S_T_NEXT;
        end
      end
      S_T_NEXT: begin
        ram_wr               = '{we: 1'b1, addr: t_r, data: ram_rdata};
        queued_nxt[h_r]      = 1'b0;
        res_nxt.served_valid = 1'b1;
        res_nxt.served_id    = prrq_pkg::ID_W'(h_r);
        res_nxt.served_level = prrq_pkg::LEVEL_W'(active_r);
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      active_r   <= '0;
      nonempty_r <= '0;
      queued_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      nonempty_r <= nonempty_nxt;
      queued_r   <= queued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    cmd_r  <= cmd_nxt;
    id_r   <= id_nxt;
    lvl_r  <= lvl_nxt;
    t_r    <= t_nxt;
    h_r    <= h_nxt;
    res_r  <= res_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);

  always_comb begin
    res           = res_r;
    res.level_now = prrq_pkg::LEVEL_W'(active_r);
  end

  `ASSERT_CLK(a_scan_steps_down, clk, rst_n,
    (state_r == S_T_SCAN && active_r != '0 && !ne_q) |=>
      (active_r == $past(active_r) - 1'b1))
  `ASSERT_CLK(a_head_is_queued, clk, rst_n,
    (state_r == S_T_HEAD) |-> queued_r[ram_rdata])
  `ASSERT_CLK(a_append_marks, clk, rst_n,
    (state_r == S_F_TAIL) |=> (queued_r[$past(e_idx)] && nonempty_r[$past(lvl_p)]))
  `ASSERT_NEVER(a_level0_empty, clk, rst_n, nonempty_r[0])

endmodule
`default_nettype wire
